// ----- src/ale_pkg.sv -----
// Shared constants, codes and control/status types for the array list engine.
`default_nettype none

package ale_pkg;

    // Default list capacity
    localparam int DEPTH_DEF = 8;

    // Field widths
    localparam int OPW  = 4;
    localparam int POSW = 8;
    localparam int VALW = 32;
    localparam int AMTW = 16;
    localparam int STW  = 3;
    localparam int FPW  = 7;

    // Operation codes
    localparam logic [OPW-1:0] OP_INS_FRONT = 4'd0;
    localparam logic [OPW-1:0] OP_INS_END   = 4'd1;
    localparam logic [OPW-1:0] OP_INS_POS   = 4'd2;
    localparam logic [OPW-1:0] OP_DEL_FRONT = 4'd3;
    localparam logic [OPW-1:0] OP_DEL_END   = 4'd4;
    localparam logic [OPW-1:0] OP_DEL_POS   = 4'd5;
    localparam logic [OPW-1:0] OP_SEARCH    = 4'd6;
    localparam logic [OPW-1:0] OP_DISPLAY   = 4'd7;
    localparam logic [OPW-1:0] OP_ROTATE    = 4'd8;

    // Status codes
    localparam logic [STW-1:0] ST_OK       = 3'd0;
    localparam logic [STW-1:0] ST_FULL     = 3'd1;
    localparam logic [STW-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STW-1:0] ST_BADPOS   = 3'd3;
    localparam logic [STW-1:0] ST_NOTFOUND = 3'd4;

    // Walk index updates
    localparam logic [2:0] I_HOLD  = 3'd0;
    localparam logic [2:0] I_COUNT = 3'd1;
    localparam logic [2:0] I_START = 3'd2;
    localparam logic [2:0] I_ZERO  = 3'd3;
    localparam logic [2:0] I_INC   = 3'd4;
    localparam logic [2:0] I_DEC   = 3'd5;

    // Store read address select
    localparam logic [1:0] RD_I   = 2'd0;
    localparam logic [1:0] RD_IM1 = 2'd1;
    localparam logic [1:0] RD_IP1 = 2'd2;

    // Store write data select
    localparam logic [1:0] WR_VAL = 2'd0;
    localparam logic [1:0] WR_MEM = 2'd1;
    localparam logic [1:0] WR_TMP = 2'd2;

    // Count updates
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic           capture;
        logic [2:0]     i_op;
        logic           mem_rd;
        logic [1:0]     rd_sel;
        logic           mem_wr;
        logic [1:0]     wr_sel;
        logic           tmp_rd;
        logic           tmp_wr;
        logic [1:0]     cnt_op;
        logic           mod_start;
        logic           j_load;
        logic           j_step;
        logic           res_load;
        logic [STW-1:0] res_status;
        logic           res_hit;
        logic           disp_load;
    } ale_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [OPW-1:0] op;
        logic           full;
        logic           empty;
        logic           ins_pos_ok;
        logic           del_pos_ok;
        logic           at_start;
        logic           at_last;
        logic           match;
        logic           mod_done;
        logic           out_free;
    } ale_stat_t;

endpackage

`default_nettype wire

// ----- src/ale_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds its word between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/ale_mod.sv -----
// Bit-serial restoring remainder unit: dividend modulo divisor, one bit per cycle.
`default_nettype none

module ale_mod #(
    parameter int NW = 16,
    parameter int DW = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic      [DW-1:0] rem
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg,  busy_next;
    logic            done_reg,  done_next;
    logic [CNTW-1:0] cnt_reg,   cnt_next;
    logic [NW-1:0]   q_reg,     q_next;
    logic [DW-1:0]   rem_reg,   rem_next;
    logic [DW:0]     trial;

    // One restoring step: shift in next dividend bit, subtract if it fits
    assign trial = {rem_reg, q_reg[NW-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNTW'(NW);
            q_next    = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            q_next = q_reg << 1;
            if (trial >= {1'b0, divisor})
            begin
                rem_next = DW'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[DW-1:0];
            end
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ----- src/ale_dp.sv -----
// Datapath: operand capture, count, walk indexes, element and scratch stores, result word.
`default_nettype none

module ale_dp import ale_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ale_cmd_t               cmd,
    output ale_stat_t                   stat,
    input  wire logic [OPW-1:0]         opcode,
    input  wire logic [POSW-1:0]        position,
    input  wire logic signed [VALW-1:0] item_value,
    input  wire logic [AMTW-1:0]        shift_amount,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic [STW-1:0]              status,
    output logic [FPW-1:0]              found_position,
    output logic signed [VALW-1:0]      element,
    output logic                        last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Captured operands
    logic [OPW-1:0]  op_reg;
    logic [POSW-1:0] pos_reg;
    logic [VALW-1:0] val_reg;
    logic [AMTW-1:0] amt_reg;

    // List state and walk indexes
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   i_reg,     i_next;
    logic [CW-1:0]   j_reg,     j_next;
    logic [CW-1:0]   i_p1, i_m1, j_p1, start_idx;
    logic [POSW:0]   cnt_ext, pos_ext;

    // Store ports
    logic [AW-1:0]   mem_rd_addr;
    logic [VALW-1:0] mem_wr_data, mem_rdata, tmp_rdata;
    logic            mod_done;
    logic [CW-1:0]   k_rem;

    // Result word
    logic            out_valid_reg;
    logic [STW-1:0]  status_reg;
    logic [FPW-1:0]  fpos_reg;
    logic [VALW-1:0] elem_reg;
    logic            last_reg;

    assign i_p1    = i_reg + CW'(1);
    assign i_m1    = i_reg - CW'(1);
    assign j_p1    = j_reg + CW'(1);
    assign cnt_ext = (POSW+1)'(count_reg);
    assign pos_ext = {1'b0, pos_reg};

    // First index touched by an insert or delete
    always_comb
    begin
        case (op_reg)
            OP_INS_END: start_idx = count_reg;
            OP_INS_POS,
            OP_DEL_POS: start_idx = CW'(pos_reg - POSW'(1));
            default:    start_idx = '0;
        endcase
    end

    // Status flags
    always_comb
    begin
        stat.op         = op_reg;
        stat.full       = (count_reg == CW'(DEPTH));
        stat.empty      = (count_reg == '0);
        stat.ins_pos_ok = (pos_reg != '0) && (pos_ext <= cnt_ext + (POSW+1)'(1));
        stat.del_pos_ok = (pos_reg != '0) && (pos_ext <= cnt_ext);
        stat.at_start   = (i_reg == start_idx);
        stat.at_last    = (i_p1 == count_reg);
        stat.match      = (mem_rdata == val_reg);
        stat.mod_done   = mod_done;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Operand capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            val_reg <= item_value;
            amt_reg <= shift_amount;
        end
    end

    // Count update
    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Walk index i and rotation target j
    always_comb
    begin
        case (cmd.i_op)
            I_COUNT: i_next = count_reg;
            I_START: i_next = start_idx;
            I_ZERO:  i_next = '0;
            I_INC:   i_next = i_p1;
            I_DEC:   i_next = i_m1;
            default: i_next = i_reg;
        endcase
        if (cmd.j_load)
        begin
            j_next = k_rem;
        end
        else if (cmd.j_step)
        begin
            j_next = (j_p1 == count_reg) ? '0 : j_p1;
        end
        else
        begin
            j_next = j_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
    end

    // Store address and data selection
    always_comb
    begin
        case (cmd.rd_sel)
            RD_IM1:  mem_rd_addr = i_m1[AW-1:0];
            RD_IP1:  mem_rd_addr = i_p1[AW-1:0];
            default: mem_rd_addr = i_reg[AW-1:0];
        endcase
        case (cmd.wr_sel)
            WR_MEM:  mem_wr_data = mem_rdata;
            WR_TMP:  mem_wr_data = tmp_rdata;
            default: mem_wr_data = val_reg;
        endcase
    end

    // Element store
    ale_ram #(
        .WIDTH (VALW),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .clk     (clk),
        .wr_en   (cmd.mem_wr),
        .wr_addr (i_reg[AW-1:0]),
        .wr_data (mem_wr_data),
        .rd_en   (cmd.mem_rd),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rdata)
    );

    // Scratch store for rotation
    ale_ram #(
        .WIDTH (VALW),
        .DEPTH (DEPTH)
    ) u_tmp_ram (
        .clk     (clk),
        .wr_en   (cmd.tmp_wr),
        .wr_addr (j_reg[AW-1:0]),
        .wr_data (mem_rdata),
        .rd_en   (cmd.tmp_rd),
        .rd_addr (i_reg[AW-1:0]),
        .rd_data (tmp_rdata)
    );

    // Rotate amount modulo count
    ale_mod #(
        .NW (AMTW),
        .DW (CW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (amt_reg),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (k_rem)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load || cmd.disp_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.disp_load)
        begin
            status_reg <= ST_OK;
            fpos_reg   <= FPW'(i_p1);
            elem_reg   <= mem_rdata;
            last_reg   <= (i_p1 == count_reg);
        end
        else if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            fpos_reg   <= cmd.res_hit ? FPW'(i_p1) : '0;
            elem_reg   <= '0;
            last_reg   <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = fpos_reg;
    assign element        = elem_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

// ----- src/ale_ctrl.sv -----
// Controller: sequences each operation over the datapath one store access at a time.
`default_nettype none

module ale_ctrl import ale_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire ale_stat_t stat,
    output ale_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_UP_CHK = 4'd2;
    localparam logic [3:0] S_UP_WR  = 4'd3;
    localparam logic [3:0] S_DN_CHK = 4'd4;
    localparam logic [3:0] S_DN_WR  = 4'd5;
    localparam logic [3:0] S_SR_RD  = 4'd6;
    localparam logic [3:0] S_SR_CMP = 4'd7;
    localparam logic [3:0] S_DP_RD  = 4'd8;
    localparam logic [3:0] S_DP_OUT = 4'd9;
    localparam logic [3:0] S_MOD    = 4'd10;
    localparam logic [3:0] S_RT_RD  = 4'd11;
    localparam logic [3:0] S_RT_WR  = 4'd12;
    localparam logic [3:0] S_CP_RD  = 4'd13;
    localparam logic [3:0] S_CP_WR  = 4'd14;
    localparam logic [3:0] S_RESULT = 4'd15;

    logic [3:0]     state_reg, state_next;
    logic [STW-1:0] st_reg,    st_next;
    logic           hit_reg,   hit_next;

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        hit_next       = hit_reg;
        cmd            = '0;
        cmd.i_op       = I_HOLD;
        cmd.rd_sel     = RD_I;
        cmd.wr_sel     = WR_VAL;
        cmd.cnt_op     = CNT_HOLD;
        cmd.res_status = st_reg;
        cmd.res_hit    = hit_reg;
        in_ready       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    hit_next    = 1'b0;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_RESULT;
                st_next    = ST_OK;
                case (stat.op) inside
                    OP_INS_FRONT, OP_INS_END, OP_INS_POS:
                    begin
                        if (stat.full)
                        begin
                            st_next = ST_FULL;
                        end
                        else if (stat.op == OP_INS_POS && !stat.ins_pos_ok)
                        begin
                            st_next = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.i_op   = I_COUNT;
                            state_next = S_UP_CHK;
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS:
                    begin
                        if (stat.empty)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (stat.op == OP_DEL_END)
                        begin
                            cmd.cnt_op = CNT_DEC;
                        end
                        else if (stat.op == OP_DEL_POS && !stat.del_pos_ok)
                        begin
                            st_next = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.i_op   = I_START;
                            state_next = S_DN_CHK;
                        end
                    end
                    OP_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            st_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.i_op   = I_ZERO;
                            state_next = S_SR_RD;
                        end
                    end
                    OP_DISPLAY:
                    begin
                        if (stat.empty)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.i_op   = I_ZERO;
                            state_next = S_DP_RD;
                        end
                    end
                    OP_ROTATE:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_MOD;
                        end
                    end
                    default:
                    begin
                        st_next = ST_BADPOS;
                    end
                endcase
            end

            // Open a slot: move words up from the top, then drop the new word in
            S_UP_CHK:
            begin
                if (stat.at_start)
                begin
                    cmd.mem_wr = 1'b1;
                    cmd.wr_sel = WR_VAL;
                    cmd.cnt_op = CNT_INC;
                    st_next    = ST_OK;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_IM1;
                    state_next = S_UP_WR;
                end
            end

            S_UP_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_sel = WR_MEM;
                cmd.i_op   = I_DEC;
                state_next = S_UP_CHK;
            end

            // Close a slot: move words down toward the removed one
            S_DN_CHK:
            begin
                if (stat.at_last)
                begin
                    cmd.cnt_op = CNT_DEC;
                    st_next    = ST_OK;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    cmd.rd_sel = RD_IP1;
                    state_next = S_DN_WR;
                end
            end

            S_DN_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_sel = WR_MEM;
                cmd.i_op   = I_INC;
                state_next = S_DN_CHK;
            end

            // Linear search for the first match
            S_SR_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_SR_CMP;
            end

            S_SR_CMP:
            begin
                if (stat.match)
                begin
                    hit_next   = 1'b1;
                    st_next    = ST_OK;
                    state_next = S_RESULT;
                end
                else if (stat.at_last)
                begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.i_op   = I_INC;
                    state_next = S_SR_RD;
                end
            end

            // Display: one result word per element
            S_DP_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_DP_OUT;
            end

            S_DP_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.disp_load = 1'b1;
                    if (stat.at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.i_op   = I_INC;
                        state_next = S_DP_RD;
                    end
                end
            end

            // Rotate: wait for the reduced amount, scatter to scratch, copy back
            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    cmd.j_load = 1'b1;
                    cmd.i_op   = I_ZERO;
                    state_next = S_RT_RD;
                end
            end

            S_RT_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_RT_WR;
            end

            S_RT_WR:
            begin
                cmd.tmp_wr = 1'b1;
                cmd.j_step = 1'b1;
                if (stat.at_last)
                begin
                    cmd.i_op   = I_ZERO;
                    state_next = S_CP_RD;
                end
                else
                begin
                    cmd.i_op   = I_INC;
                    state_next = S_RT_RD;
                end
            end

            S_CP_RD:
            begin
                cmd.tmp_rd = 1'b1;
                state_next = S_CP_WR;
            end

            S_CP_WR:
            begin
                cmd.mem_wr = 1'b1;
                cmd.wr_sel = WR_TMP;
                if (stat.at_last)
                begin
                    st_next    = ST_OK;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.i_op   = I_INC;
                    state_next = S_CP_RD;
                end
            end

            // Single closing result word
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            hit_reg   <= hit_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/array_list_engine.sv -----
// Array list engine top level: bounded ordered list of signed 32-bit words.
//
// Input channel (in_valid/in_ready) takes one operation word: opcode, position,
// item_value, shift_amount. The engine works on one operation at a time and
// raises in_ready only when idle. Output channel (out_valid/out_ready) carries
// result words: status, found_position, element, last. Every operation gives a
// single word with last set, except display of a non-empty list, which gives
// one word per element with last set on the final one.
// Each operation runs over the registered-read element store, one access
// per cycle at most (none while waiting on the output register or the
// remainder unit); a word is moved by a read and then its write-back:
//   insert/delete: a read and a write-back per word moved
//   search:        a read and a compare per word, up to the match
//   display:       a read and then a result word per element
//   rotate:        remainder unit, then scatter to a scratch store and copy back
// Reset clears the count and control state; the store contents are left as
// they are and no clearing pass runs. A result word waits in the output
// register while out_ready is low; the engine stalls on the next result only.
`default_nettype none

module array_list_engine import ale_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [OPW-1:0]         opcode,
    input  wire logic [POSW-1:0]        position,
    input  wire logic signed [VALW-1:0] item_value,
    input  wire logic [AMTW-1:0]        shift_amount,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [STW-1:0]              status,
    output logic [FPW-1:0]              found_position,
    output logic signed [VALW-1:0]      element,
    output logic                        last
);

    ale_cmd_t  cmd;
    ale_stat_t stat;

    ale_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ale_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .position       (position),
        .item_value     (item_value),
        .shift_amount   (shift_amount),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .found_position (found_position),
        .element        (element),
        .last           (last)
    );

endmodule

`default_nettype wire

// ----- bench/array_list_checker.sv -----
// Scoreboard for the array list engine: tracks the list, predicts result words, compares them.
module array_list_checker import ale_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic [OPW-1:0]         opcode,
    input  wire logic [POSW-1:0]        position,
    input  wire logic signed [VALW-1:0] item_value,
    input  wire logic [AMTW-1:0]        shift_amount,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [STW-1:0]         status,
    input  wire logic [FPW-1:0]         found_position,
    input  wire logic signed [VALW-1:0] element,
    input  wire logic                   last,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic [STW-1:0]         status;
        logic [FPW-1:0]         pos;
        logic signed [VALW-1:0] element;
        logic                   last;
    } result_word_t;

    // Shadow copy of the list and the result words still owed by the engine
    logic signed [VALW-1:0] list_mem [DEPTH];
    int                     list_count = 0;
    result_word_t           results_due [$];
    int                     mismatches = 0;
    int                     words_due = 0;

    assign fail_count = mismatches;
    assign pending    = words_due;

    task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
        mismatches++;
    endtask

    // Shift later entries up and store v at idx (0-based)
    function automatic void open_slot(input int idx, input logic signed [VALW-1:0] v);
        for (int i = list_count; i > idx; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[idx] = v;
        list_count++;
    endfunction

    // Remove the entry at idx (0-based), shifting later entries down
    function automatic void close_slot(input int idx);
        for (int i = idx; i + 1 < list_count; i++)
            list_mem[i] = list_mem[i+1];
        list_count--;
    endfunction

    // Apply one operation word to the shadow list and queue the words it yields
    function automatic void predict_list_op(input logic [OPW-1:0] op,
                                            input logic [POSW-1:0] pos,
                                            input logic signed [VALW-1:0] val,
                                            input logic [AMTW-1:0] amt);
        logic signed [VALW-1:0] spun [DEPTH];
        logic [STW-1:0]         st;
        logic [FPW-1:0]         hit;
        int                     k;
        st  = ST_OK;
        hit = '0;
        case (op)
            OP_INS_FRONT, OP_INS_END, OP_INS_POS:
            begin
                if (list_count >= DEPTH)
                    st = ST_FULL;
                else if (op == OP_INS_FRONT)
                    open_slot(0, val);
                else if (op == OP_INS_END)
                    open_slot(list_count, val);
                else if (int'(pos) < 1 || int'(pos) > list_count + 1)
                    st = ST_BADPOS;
                else
                    open_slot(int'(pos) - 1, val);
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS:
            begin
                if (list_count == 0)
                    st = ST_EMPTY;
                else if (op == OP_DEL_FRONT)
                    close_slot(0);
                else if (op == OP_DEL_END)
                    list_count--;
                else if (int'(pos) < 1 || int'(pos) > list_count)
                    st = ST_BADPOS;
                else
                    close_slot(int'(pos) - 1);
            end
            OP_SEARCH:
            begin
                // first match wins
                st = ST_NOTFOUND;
                for (int i = 0; i < list_count; i++)
                begin
                    if (st == ST_NOTFOUND && list_mem[i] == val)
                    begin
                        st  = ST_OK;
                        hit = FPW'(i + 1);
                    end
                end
            end
            OP_DISPLAY:
            begin
                if (list_count == 0)
                    st = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < list_count; i++)
                        results_due.push_back({ST_OK, FPW'(i + 1), list_mem[i],
                                               (i == list_count - 1)});
                    return;
                end
            end
            OP_ROTATE:
            begin
                // rotate right by amt mod count; empty list is left alone
                if (list_count != 0)
                begin
                    k = int'(amt) % list_count;
                    for (int i = 0; i < list_count; i++)
                        spun[(i + k) % list_count] = list_mem[i];
                    for (int i = 0; i < list_count; i++)
                        list_mem[i] = spun[i];
                end
            end
            default:
                st = ST_BADPOS;
        endcase
        results_due.push_back({st, hit, VALW'(0), 1'b1});
    endfunction

    // Watch both channels at the rising edge
    always @(posedge clk)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            list_count = 0;
            results_due.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                predict_list_op(opcode, position, item_value, shift_amount);
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected result word (status)", -1, status);
                else
                begin
                    want = results_due.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", want.status, status);
                    if (found_position !== want.pos)
                        report_mismatch("found_position", want.pos, found_position);
                    if (element !== want.element)
                        report_mismatch("element", $signed(want.element), element);
                    if (last !== want.last)
                        report_mismatch("last", want.last, last);
                end
            end
        end
        words_due = results_due.size();
    end

endmodule

// ----- bench/tb.sv -----
// Top-level testbench for the array list engine: stimulus, output stalls, watchdog, verdict.
module tb;
    import ale_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_WORDS = 430;

    // opcodes the engine does not define
    localparam logic [OPW-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OPW-1:0] OP_UNUSED_HI = 4'd15;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [OPW-1:0]         opcode;
    logic [POSW-1:0]        position;
    logic signed [VALW-1:0] item_value;
    logic [AMTW-1:0]        shift_amount;
    logic                   out_valid;
    logic                   out_ready;
    logic [STW-1:0]         status;
    logic [FPW-1:0]         found_position;
    logic signed [VALW-1:0] element;
    logic                   last;
    int                     fail_count;
    int                     pending;

    int                     in_idle_max = 0;
    int                     out_idle_max = 0;
    int                     hold_request = 0;
    int                     quiet_cycles = 0;
    logic signed [VALW-1:0] value_pool [16];

    always #4 clk = ~clk;

    array_list_engine i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .position       (position),
        .item_value     (item_value),
        .shift_amount   (shift_amount),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_position (found_position),
        .element        (element),
        .last           (last)
    );

    array_list_checker i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .position       (position),
        .item_value     (item_value),
        .shift_amount   (shift_amount),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .found_position (found_position),
        .element        (element),
        .last           (last),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    function automatic int idle_limit();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 3;
            default: return 14;
        endcase
    endfunction

    // Offer one operation word after a random gap; returns once it is taken
    task automatic send_word(input logic [OPW-1:0] op, input logic [POSW-1:0] pos,
                             input logic signed [VALW-1:0] val, input logic [AMTW-1:0] amt);
        int gap;
        gap = $urandom_range(0, in_idle_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        position     <= pos;
        item_value   <= val;
        shift_amount <= amt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop offering and hold off new words until every owed result word has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Result side: random stall per word, with an occasional long hold-off
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, out_idle_max);
            if (hold_request > 0)
            begin
                gap = hold_request;
                hold_request = 0;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Watchdog: too long without any word moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [OPW-1:0]         op;
        logic [POSW-1:0]        pos;
        logic signed [VALW-1:0] val;
        logic [AMTW-1:0]        amt;
        logic                   filling;
        int                     r;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_INS_FRONT;
        position     = '0;
        item_value   = '0;
        shift_amount = '0;

        // values reused often so searches hit
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < 16; i++)
            value_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty list corners
        send_word(OP_DISPLAY, 8'd0, '0, '0);
        send_word(OP_DEL_FRONT, 8'd0, '0, '0);
        send_word(OP_DEL_END, 8'd0, '0, '0);
        send_word(OP_DEL_POS, 8'd1, '0, '0);
        send_word(OP_SEARCH, 8'd0, '0, '0);
        send_word(OP_ROTATE, 8'd0, '0, 16'd5);
        send_word(OP_INS_POS, 8'd2, 32'sd99, '0);
        // fill to capacity through every insert flavor
        send_word(OP_INS_POS, 8'd1, 32'sh8000_0000, '0);
        send_word(OP_INS_FRONT, 8'd0, 32'sh7fff_ffff, '0);
        send_word(OP_INS_END, 8'd0, -32'sd1, '0);
        send_word(OP_INS_POS, 8'd2, '0, '0);
        send_word(OP_INS_POS, 8'd5, 32'sd1234, '0);
        send_word(OP_INS_FRONT, 8'd0, 32'sh5555_5555, '0);
        send_word(OP_INS_END, 8'd0, 32'shaaaa_aaaa, '0);
        send_word(OP_INS_POS, 8'd8, 32'sd7, '0);
        // full list
        send_word(OP_INS_END, 8'd0, 32'sd3, '0);
        send_word(OP_INS_POS, 8'd255, 32'sd3, '0);
        send_word(OP_DISPLAY, 8'd0, '0, '0);
        send_word(OP_SEARCH, 8'd0, 32'sd7, '0);
        send_word(OP_SEARCH, 8'd0, 32'sd42, '0);
        send_word(OP_ROTATE, 8'd0, '0, 16'hffff);
        // bad and good positional deletes, then the ends
        send_word(OP_DEL_POS, 8'd0, '0, '0);
        send_word(OP_DEL_POS, 8'd9, '0, '0);
        send_word(OP_DEL_POS, 8'd8, '0, '0);
        send_word(OP_DEL_FRONT, 8'd0, '0, '0);
        send_word(OP_DEL_END, 8'd0, '0, '0);
        send_word(OP_UNUSED_LO, 8'd0, '0, '0);
        send_word(OP_UNUSED_HI, 8'hff, 32'shffff_ffff, 16'hffff);
        wait_drained();

        // Random: alternating fill-heavy and drain-heavy phases
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0)
            begin
                in_idle_max  = idle_limit();
                out_idle_max = idle_limit();
            end
            filling = ((n / 40) % 2 == 0);
            // receiver goes quiet while words keep coming
            if (n == 150)
                hold_request = 300;
            // sender waits for the engine to empty out
            if (n == 300)
                wait_drained();

            r = $urandom_range(0, 99);
            if (r < 3)
                op = OPW'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
            else if (r < 10)
                op = OP_DISPLAY;
            else if (r < 20)
                op = OP_ROTATE;
            else if (r < 32)
                op = OP_SEARCH;
            else if (r < (filling ? 82 : 50))
            begin
                case ($urandom_range(0, 2))
                    0: op = OP_INS_FRONT;
                    1: op = OP_INS_END;
                    default: op = OP_INS_POS;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: op = OP_DEL_FRONT;
                    1: op = OP_DEL_END;
                    default: op = OP_DEL_POS;
                endcase
            end

            pos = ($urandom_range(0, 4) != 0) ? POSW'($urandom_range(0, 10))
                                              : POSW'($urandom_range(0, 255));
            val = ($urandom_range(0, 9) < (op == OP_SEARCH ? 8 : 5))
                  ? value_pool[$urandom_range(0, 15)] : $urandom;
            amt = $urandom_range(0, 1) ? AMTW'($urandom_range(0, 20)) : AMTW'($urandom);
            send_word(op, pos, val, amt);
        end

        wait_drained();
        // room for a stray word from a slow rotate
        repeat (80) @(negedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
